FILE: rtl/hpmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpmc_pkg - shared definitions for half-pel motion compensation
// Pixel and size widths, register indexes, default limits and the record
// that moves from the front end through the work queue to the back end.
// ----------------------------------------------------------------------------
package hpmc_pkg;

   // pixel and field widths
   localparam int PIX_W      = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 5;

   // width used for size arithmetic; holds the largest region width (32)
   localparam int SIZE_W = 7;

   // default block limits
   localparam int DEF_MAX_WIDTH  = 16;
   localparam int DEF_MAX_HEIGHT = 16;

   // work queue between front and back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register reset values
   localparam logic [CSR_DATA_W-1:0] BLOCK_WIDTH_RST  = CSR_DATA_W'(16);
   localparam logic [CSR_DATA_W-1:0] BLOCK_HEIGHT_RST = CSR_DATA_W'(16);

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_X       = 3'd0,
      CSR_HALF_Y       = 3'd1,
      CSR_AVERAGE_MODE = 3'd2,
      CSR_BLOCK_WIDTH  = 3'd3,
      CSR_BLOCK_HEIGHT = 3'd4
   } csr_index_type;

   // one classified pixel awaiting interpolation
   typedef struct packed {
      logic             half_x;
      logic             half_y;
      logic             average_mode;
      logic             last;
      logic [PIX_W-1:0] cur;
      logic [PIX_W-1:0] dst;
      logic [PIX_W-1:0] left;
      logic [PIX_W-1:0] up;
      logic [PIX_W-1:0] upleft;
   } work_item_type;

endpackage

FILE: rtl/hpmc_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpmc_ifs - channel interfaces
// Request, response and register write channels, each a valid/ready pair
// with its payload and a source and sink view.
// ----------------------------------------------------------------------------
interface hpmc_req_if;
   logic                       valid;
   logic                       ready;
   logic [hpmc_pkg::PIX_W-1:0] ref_pixel;
   logic [hpmc_pkg::PIX_W-1:0] dest_pixel;

   modport source (output valid, output ref_pixel, output dest_pixel, input ready);
   modport sink   (input valid, input ref_pixel, input dest_pixel, output ready);
endinterface

interface hpmc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [hpmc_pkg::PIX_W-1:0] pred_pixel;
   logic                       block_last;

   modport source (output valid, output pred_pixel, output block_last, input ready);
   modport sink   (input valid, input pred_pixel, input block_last, output ready);
endinterface

interface hpmc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [hpmc_pkg::CSR_IDX_W-1:0]  index;
   logic [hpmc_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/half_pel_motion_compensation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_pel_motion_compensation_top - half-pel motion-compensated prediction
// Predicts one block from a raster stream of reference pixels.
// ----------------------------------------------------------------------------
// Usage:
//  - csr_ch writes the flags and block size by register index; writes are
//    always taken and should only be issued while the block is idle.
//  - req_ch carries one reference pixel of the source region per
//    transaction, in raster order, with the destination pixel alongside.
//    The region is (width + half_x) by (height + half_y) pixels.
//  - rsp_ch returns one predicted pixel for every reference pixel that
//    completes a predicted position; block_last marks the final one.
//  - Throughput: one pixel per cycle unless the receiver stalls, set by
//    the line store taking one read and one write per cycle in the front
//    end. A result passes the front stage, work queue and output register.
//  - A receiver stall fills the four-entry work queue; req_ch.ready drops
//    once the queue and the front stage together hold four pixels, and
//    nothing is lost.
//  - Reset clears registers to their defaults, the position to the region
//    origin and empties the queue; the line store is not cleared.
// ----------------------------------------------------------------------------
module half_pel_motion_compensation_top #(
   parameter int MAX_WIDTH  = hpmc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = hpmc_pkg::DEF_MAX_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   hpmc_req_if.sink    req_ch,
   hpmc_rsp_if.source  rsp_ch,
   hpmc_csr_if.sink    csr_ch
);
   import hpmc_pkg::*;

   logic                push;
   work_item_type       push_item;
   logic                pop;
   logic                head_valid;
   work_item_type       head_item;
   logic [QCNT_W-1:0]   queue_count;

   // accept, classify and read the line store
   hpmc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .csr_ch      (csr_ch),
      .queue_count (queue_count),
      .item_valid  (push),
      .item        (push_item)
   );

   // decouple front and back end
   hpmc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .count      (queue_count)
   );

   // interpolate and present results
   hpmc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

FILE: rtl/hpmc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpmc_ram - generic single-write, single-read RAM
// One write port and one registered read port; a read and a write to the
// same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module hpmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 17
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write, and read the old contents
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/hpmc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpmc_queue - work queue between front and back end
// Small register FIFO of classified pixels; the fill count goes back to the
// front end for flow control.
// ----------------------------------------------------------------------------
module hpmc_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  hpmc_pkg::work_item_type       push_item,
   input  logic                          pop,
   output logic                          head_valid,
   output hpmc_pkg::work_item_type       head_item,
   output logic [hpmc_pkg::QCNT_W-1:0]   count
);
   import hpmc_pkg::*;

   work_item_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed transaction
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

FILE: rtl/hpmc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpmc_front - front end of half-pel motion compensation
// Holds the control registers, accepts reference pixels, tracks the position
// in the source region, keeps the previous row in a line store and decides
// which pixels complete a predicted position.
// ----------------------------------------------------------------------------
module hpmc_front #(
   parameter int MAX_WIDTH  = hpmc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = hpmc_pkg::DEF_MAX_HEIGHT
) (
   input  logic                        clock,
   input  logic                        reset,
   hpmc_req_if.sink                    req_ch,
   hpmc_csr_if.sink                    csr_ch,
   input  logic [hpmc_pkg::QCNT_W-1:0] queue_count,
   output logic                        item_valid,
   output hpmc_pkg::work_item_type     item
);
   import hpmc_pkg::*;

   localparam int COL_DEPTH = MAX_WIDTH + 1;
   localparam int COL_W     = $clog2(COL_DEPTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT + 1);

   // control registers
   logic                  half_x_ff;
   logic                  half_y_ff;
   logic                  average_mode_ff;
   logic [CSR_DATA_W-1:0] block_width_ff;
   logic [CSR_DATA_W-1:0] block_height_ff;

   // position and neighbour registers
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [PIX_W-1:0] left_ff;
   logic [PIX_W-1:0] upleft_ff;

   // stage register holding the pixel while the line store is read
   logic             s1_valid_ff;
   logic             s1_produce_ff;
   work_item_type    s1_item_ff;

   logic [SIZE_W-1:0] bw, bh, rw, rh;
   logic [SIZE_W-1:0] col_ext, row_ext, col_inc, row_inc;
   logic              accept;
   logic              produce;
   logic              last;
   logic [PIX_W-1:0]  up_data;
   logic [QCNT_W:0]   in_flight;

   // register writes, always taken
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_x_ff       <= 1'b0;
         half_y_ff       <= 1'b0;
         average_mode_ff <= 1'b0;
         block_width_ff  <= BLOCK_WIDTH_RST;
         block_height_ff <= BLOCK_HEIGHT_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_HALF_X:       half_x_ff       <= csr_ch.data[0];
            CSR_HALF_Y:       half_y_ff       <= csr_ch.data[0];
            CSR_AVERAGE_MODE: average_mode_ff <= csr_ch.data[0];
            CSR_BLOCK_WIDTH:  block_width_ff  <= csr_ch.data;
            CSR_BLOCK_HEIGHT: block_height_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // clamp sizes into 1..max and form the region size
   always_comb begin
      if (block_width_ff == '0) begin
         bw = SIZE_W'(1);
      end else if (SIZE_W'(block_width_ff) > SIZE_W'(MAX_WIDTH)) begin
         bw = SIZE_W'(MAX_WIDTH);
      end else begin
         bw = SIZE_W'(block_width_ff);
      end
      if (block_height_ff == '0) begin
         bh = SIZE_W'(1);
      end else if (SIZE_W'(block_height_ff) > SIZE_W'(MAX_HEIGHT)) begin
         bh = SIZE_W'(MAX_HEIGHT);
      end else begin
         bh = SIZE_W'(block_height_ff);
      end
      rw = bw + SIZE_W'(half_x_ff);
      rh = bh + SIZE_W'(half_y_ff);
   end

   // hold off while the queue cannot take every transaction in flight
   assign in_flight    = (QCNT_W + 1)'(queue_count) + (QCNT_W + 1)'(s1_valid_ff);
   assign req_ch.ready = !reset && (in_flight < (QCNT_W + 1)'(QUEUE_DEPTH));
   assign accept       = req_ch.valid && req_ch.ready;

   // classify the position: border pixels and positions outside give nothing
   always_comb begin
      col_ext = SIZE_W'(col_ff);
      row_ext = SIZE_W'(row_ff);
      col_inc = col_ext + SIZE_W'(1);
      row_inc = row_ext + SIZE_W'(1);
      produce = (col_ext >= SIZE_W'(half_x_ff)) && (row_ext >= SIZE_W'(half_y_ff)) &&
                (col_ext < rw) && (row_ext < rh);
      last    = (col_inc == rw) && (row_inc == rh);
   end

   // advance the raster position, wrap at row and region end
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_inc >= rw) begin
            col_in = '0;
            row_in = (row_inc >= rh) ? '0 : row_inc[ROW_W-1:0];
         end else begin
            col_in = col_inc[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         left_ff     <= '0;
         upleft_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
         if (accept) begin
            left_ff <= req_ch.ref_pixel;
         end
         if (s1_valid_ff) begin
            upleft_ff <= up_data;
         end
      end
   end

   // capture the transaction while the line store is read
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_produce_ff           <= produce;
         s1_item_ff.half_x       <= half_x_ff;
         s1_item_ff.half_y       <= half_y_ff;
         s1_item_ff.average_mode <= average_mode_ff;
         s1_item_ff.last         <= last;
         s1_item_ff.cur          <= req_ch.ref_pixel;
         s1_item_ff.dst          <= req_ch.dest_pixel;
         s1_item_ff.left         <= left_ff;
         s1_item_ff.up           <= '0;
         s1_item_ff.upleft       <= '0;
      end
   end

   // line store of the previous region row
   hpmc_ram #(
      .WIDTH (PIX_W),
      .DEPTH (COL_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (req_ch.ref_pixel),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (up_data)
   );

   // pass on only pixels that complete a predicted position
   always_comb begin
      item        = s1_item_ff;
      item.up     = up_data;
      item.upleft = upleft_ff;
   end
   assign item_valid = s1_valid_ff && s1_produce_ff;

endmodule

FILE: rtl/hpmc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpmc_back - back end of half-pel motion compensation
// Takes classified pixels from the work queue, forms the half-pel average
// and the optional average with the destination, and holds the result in
// an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module hpmc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  hpmc_pkg::work_item_type head_item,
   output logic                    pop,
   hpmc_rsp_if.source              rsp_ch
);
   import hpmc_pkg::*;

   logic             out_valid_ff, out_valid_in;
   logic [PIX_W-1:0] pred_ff;
   logic             last_ff;

   logic [PIX_W:0]   sum_x;
   logic [PIX_W:0]   sum_y;
   logic [PIX_W+1:0] sum_xy;
   logic [PIX_W:0]   sum_dst;
   logic [PIX_W-1:0] interp;
   logic [PIX_W-1:0] pred;

   // half-pel interpolation
   always_comb begin
      sum_x  = {1'b0, head_item.left} + {1'b0, head_item.cur} + (PIX_W + 1)'(1);
      sum_y  = {1'b0, head_item.up} + {1'b0, head_item.cur} + (PIX_W + 1)'(1);
      sum_xy = {2'b00, head_item.upleft} + {2'b00, head_item.up} +
               {2'b00, head_item.left} + {2'b00, head_item.cur} + (PIX_W + 2)'(2);
      case ({head_item.half_x, head_item.half_y})
         2'b11:   interp = sum_xy[PIX_W+1:2];
         2'b10:   interp = sum_x[PIX_W:1];
         2'b01:   interp = sum_y[PIX_W:1];
         default: interp = head_item.cur;
      endcase
      sum_dst = {1'b0, head_item.dst} + {1'b0, interp} + (PIX_W + 1)'(1);
      pred    = head_item.average_mode ? sum_dst[PIX_W:1] : interp;
   end

   // load the output register when it is empty or being taken
   assign pop          = head_valid && (!out_valid_ff || rsp_ch.ready);
   assign out_valid_in = pop || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         pred_ff <= pred;
         last_ff <= head_item.last;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.pred_pixel = pred_ff;
   assign rsp_ch.block_last = last_ff;

endmodule

FILE: rtl/hpmc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpmc_checker - port-level checks for half-pel motion compensation
// Watches the request and response channels for reset behaviour, result
// timing, held results under receiver stalls and input hold-off in reset.
// ----------------------------------------------------------------------------
module hpmc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [hpmc_pkg::PIX_W-1:0] rsp_pred_pixel,
   input logic                       rsp_block_last
);
   import hpmc_pkg::*;

   logic req_take;
   logic rsp_stall;

   assign req_take  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   // reset empties the result path
   a_reset_clears : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result still valid after reset");

   // a stalled result holds
   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      rsp_stall |=> rsp_valid && $stable(rsp_pred_pixel) && $stable(rsp_block_last))
      else $error("stalled result changed");

   // an idle output wakes once the pixel that fills it has passed the front stage and the work queue
   a_result_latency : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_take, 3))
      else $error("result appeared without a matching transaction");

   // hold the input off while reset is asserted
   a_reset_holds_input : assert property (@(posedge clock)
      reset |-> !req_ready)
      else $error("request taken during reset");

endmodule

bind half_pel_motion_compensation_top hpmc_checker u_hpmc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_pred_pixel (rsp_ch.pred_pixel),
   .rsp_block_last (rsp_ch.block_last)
);
